FILE: rtl/rdr_pkg.sv
// Shared types and constants for the radial dead-zone rescale unit.
// No dependencies; imported by the top level and its checker.
package rdr_pkg;

	// Source of the corrected magnitude after the range map.
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FULL,
		SEL_QUOT
	} map_sel_t;

	// Register indexes, decoded from the word address.
	localparam logic REG_INNER = 1'b0;
	localparam logic REG_OUTER = 1'b1;

endpackage

FILE: rtl/radial_deadzone_rescale_unit.sv
// Radial dead-zone rescale: top level with APB registers and output skid.
// Depends on rdr_pkg, rdr_isqrt and rdr_div.
//
// Takes one signed stick sample per cycle while the skid entry is empty and
// returns it rescaled along its own direction, with the radius mapped from
// [inner, outer] onto full scale. The pipeline runs through the bit-per-stage
// square root (SAMPLE_BITS stages), the bit-per-stage range-map divider and
// the parallel x/y rescale dividers (SAMPLE_BITS-1 stages each), plus
// magnitude, squaring, sum, map, product, sign and output register stages. A two-entry
// output (register plus skid) lets the pipeline keep taking samples while a
// result waits. Registers: inner_deadzone at 0x0, outer_deadzone at 0x4;
// write them only while the unit is idle.
module radial_deadzone_rescale_unit
	import rdr_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] raw_x,
	input  logic signed [SAMPLE_BITS-1:0] raw_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] corrected_x,
	output logic signed [SAMPLE_BITS-1:0] corrected_y,
	output logic [SAMPLE_BITS-2:0]        magnitude
);

	localparam int W  = SAMPLE_BITS;
	localparam int MW = W - 1;
	localparam logic [MW-1:0] FULL = {MW{1'b1}};
	localparam int ITW = 2 * W + 2;
	localparam int MTW = 2 + W + 2 * W + 2;
	localparam int XTW = 2 + MW;

	logic [MW-1:0] inner_q, outer_q;
	logic          en;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= '0;
			outer_q <= FULL;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_INNER: inner_q <= pwdata[MW-1:0];
				REG_OUTER: outer_q <= pwdata[MW-1:0];
				default: ;
			endcase
		end
	end
	assign prdata = (paddr[2] == REG_OUTER) ? 32'(outer_q) : 32'(inner_q);

	// Stage 1: magnitudes and signs
	logic         v_s1, sx_s1, sy_s1;
	logic [W-1:0] ax_s1, ay_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= raw_x[W-1];
			sy_s1 <= raw_y[W-1];
			ax_s1 <= raw_x[W-1] ? W'(-raw_x) : W'(raw_x);
			ay_s1 <= raw_y[W-1] ? W'(-raw_y) : W'(raw_y);
		end
	end

	// Stage 2: squares
	logic           v_s2, sx_s2, sy_s2;
	logic [W-1:0]   ax_s2, ay_s2;
	logic [2*W-1:0] sqx_s2, sqy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sqx_s2 <= (2*W)'(ax_s1) * (2*W)'(ax_s1);
			sqy_s2 <= (2*W)'(ay_s1) * (2*W)'(ay_s1);
		end
	end

	// Stage 3: sum of squares
	logic           v_s3, sx_s3, sy_s3;
	logic [W-1:0]   ax_s3, ay_s3;
	logic [2*W-1:0] sum_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			sum_s3 <= sqx_s2 + sqy_s2;
		end
	end

	// Radius
	logic           sq_valid;
	logic [W-1:0]   sq_root;
	logic [ITW-1:0] sq_tag;
	rdr_isqrt #(.W(W), .TW(ITW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.n        (sum_s3),
		.tag      ({ax_s3, ay_s3, sx_s3, sy_s3}),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_tag  (sq_tag)
	);

	// Stage 4: range map classification and division operands
	map_sel_t        sel_c;
	logic [MW-1:0]   d_c;
	logic            v_s4;
	map_sel_t        sel_s4;
	logic [2*MW-1:0] num_s4;
	logic [MW-1:0]   den_s4;
	logic [W-1:0]    r_s4;
	logic [ITW-1:0]  tag_s4;
	always_comb begin
		d_c = MW'(sq_root - W'(inner_q));
		priority if (outer_q <= inner_q) begin
			sel_c = (sq_root > W'(inner_q)) ? SEL_FULL : SEL_ZERO;
		end else if (sq_root <= W'(inner_q)) begin
			sel_c = SEL_ZERO;
		end else if (sq_root >= W'(outer_q)) begin
			sel_c = SEL_FULL;
		end else begin
			sel_c = SEL_QUOT;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sel_s4 <= sel_c;
			num_s4 <= {d_c, {MW{1'b0}}} - (2*MW)'(d_c);
			den_s4 <= outer_q - inner_q;
			r_s4   <= sq_root;
			tag_s4 <= sq_tag;
		end
	end

	// Range map division
	logic           md_valid;
	logic [MW-1:0]  md_quo;
	logic [MTW-1:0] md_tag;
	rdr_div #(.NW(2*MW), .DW(MW), .QW(MW), .TW(MTW)) u_map_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (num_s4),
		.den      (den_s4),
		.tag      ({sel_s4, r_s4, tag_s4}),
		.out_valid(md_valid),
		.quo      (md_quo),
		.out_tag  (md_tag)
	);

	// Stage 5: select magnitude, form products
	logic [1:0]    md_sel_bits;
	map_sel_t      md_sel;
	logic [W-1:0]  md_r, md_ax, md_ay;
	logic          md_sx, md_sy;
	logic [MW-1:0] m_c;
	assign {md_sel_bits, md_r, md_ax, md_ay, md_sx, md_sy} = md_tag;
	assign md_sel = map_sel_t'(md_sel_bits);
	always_comb begin
		unique case (md_sel)
			SEL_ZERO: m_c = '0;
			SEL_FULL: m_c = FULL;
			SEL_QUOT: m_c = md_quo;
			default:  m_c = '0;
		endcase
	end

	logic            v_s5, sx_s5, sy_s5, rz_s5;
	logic [MW-1:0]   m_s5;
	logic [W-1:0]    r_s5;
	logic [2*W-2:0]  px_s5, py_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= md_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s5 <= md_sx;
			sy_s5 <= md_sy;
			rz_s5 <= (md_r == '0);
			m_s5  <= m_c;
			r_s5  <= md_r;
			px_s5 <= (2*W-1)'(md_ax) * (2*W-1)'(m_c);
			py_s5 <= (2*W-1)'(md_ay) * (2*W-1)'(m_c);
		end
	end

	// Rescale divisions by the radius
	logic           dx_valid, dy_valid, dy_sy;
	logic [MW-1:0]  qx, qy;
	logic [XTW-1:0] dx_tag;
	rdr_div #(.NW(2*W-1), .DW(W), .QW(MW), .TW(XTW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.num      (px_s5),
		.den      (r_s5),
		.tag      ({sx_s5, rz_s5, m_s5}),
		.out_valid(dx_valid),
		.quo      (qx),
		.out_tag  (dx_tag)
	);
	rdr_div #(.NW(2*W-1), .DW(W), .QW(MW), .TW(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.num      (py_s5),
		.den      (r_s5),
		.tag      (sy_s5),
		.out_valid(dy_valid),
		.quo      (qy),
		.out_tag  (dy_sy)
	);

	// Stage 6: restore signs, zero radius gives zero
	logic          dx_sx, dx_rz;
	logic [MW-1:0] dx_m;
	assign {dx_sx, dx_rz, dx_m} = dx_tag;

	logic          v_s6;
	logic [W-1:0]  cx_s6, cy_s6;
	logic [MW-1:0] m_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dx_valid && dy_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_s6 <= dx_m;
			if (dx_rz) begin
				cx_s6 <= '0;
				cy_s6 <= '0;
			end else begin
				cx_s6 <= dx_sx ? W'(0) - W'(qx) : W'(qx);
				cy_s6 <= dy_sy ? W'(0) - W'(qy) : W'(qy);
			end
		end
	end

	// Output register with skid entry; hold the pipeline while the skid is full
	logic          out_v_q, skid_v_q;
	logic [W-1:0]  out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic [MW-1:0] out_m_q, skid_m_q;
	logic          out_load;

	assign en       = !skid_v_q;
	assign in_ready = en;
	assign out_load = out_ready || !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q  <= skid_v_q || v_s6;
			skid_v_q <= 1'b0;
		end else if (v_s6 && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_v_q) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_m_q <= skid_m_q;
			end else begin
				out_x_q <= cx_s6;
				out_y_q <= cy_s6;
				out_m_q <= m_s6;
			end
		end else if (v_s6 && en) begin
			skid_x_q <= cx_s6;
			skid_y_q <= cy_s6;
			skid_m_q <= m_s6;
		end
	end

	assign out_valid   = out_v_q;
	assign corrected_x = out_x_q;
	assign corrected_y = out_y_q;
	assign magnitude   = out_m_q;

endmodule

FILE: rtl/rdr_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Standalone; used by radial_deadzone_rescale_unit.
module rdr_isqrt #(
	parameter int W  = 16,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*W-1:0]  n,
	input  logic [TW-1:0]   tag,
	output logic            out_valid,
	output logic [W-1:0]    root,
	output logic [TW-1:0]   out_tag
);

	localparam int DW = 2 * W + 1;

	logic            v_p    [0:W];
	logic [2*W-1:0]  rem_p  [0:W];
	logic [W-1:0]    root_p [0:W];
	logic [TW-1:0]   tag_p  [0:W];

	assign v_p[0]    = in_valid;
	assign rem_p[0]  = n;
	assign root_p[0] = '0;
	assign tag_p[0]  = tag;

	for (genvar k = 0; k < W; k++) begin : g_step
		localparam int B = W - 1 - k;
		logic [DW-1:0]  delta;
		logic           take;
		logic [2*W-1:0] rem_n;
		logic [W-1:0]   root_n;

		// Try setting root bit B: cost is 2^(B+1)*root + 4^B
		always_comb begin
			delta  = (DW'(root_p[k]) << (B + 1)) + (DW'(1) << (2 * B));
			take   = DW'(rem_p[k]) >= delta;
			rem_n  = take ? (2*W)'(DW'(rem_p[k]) - delta) : rem_p[k];
			root_n = take ? (root_p[k] | (W'(1) << B)) : root_p[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else if (en) begin
				v_p[k+1] <= v_p[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k+1]  <= rem_n;
				root_p[k+1] <= root_n;
				tag_p[k+1]  <= tag_p[k];
			end
		end
	end

	assign out_valid = v_p[W];
	assign root      = root_p[W];
	assign out_tag   = tag_p[W];

endmodule

FILE: rtl/rdr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; quotient must fit QW bits. Used by radial_deadzone_rescale_unit.
module rdr_div #(
	parameter int NW = 30,
	parameter int DW = 15,
	parameter int QW = 15,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] out_tag
);

	localparam int XW = NW + DW + QW;

	logic          v_p   [0:QW];
	logic [NW-1:0] rem_p [0:QW];
	logic [DW-1:0] den_p [0:QW];
	logic [QW-1:0] quo_p [0:QW];
	logic [TW-1:0] tag_p [0:QW];

	assign v_p[0]   = in_valid;
	assign rem_p[0] = num;
	assign den_p[0] = den;
	assign quo_p[0] = '0;
	assign tag_p[0] = tag;

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic [XW-1:0] shd;
		logic          take;
		logic [NW-1:0] rem_n;
		logic [QW-1:0] quo_n;

		// Compare and subtract the divisor shifted to bit B
		always_comb begin
			shd   = XW'(den_p[k]) << B;
			take  = XW'(rem_p[k]) >= shd;
			rem_n = take ? NW'(XW'(rem_p[k]) - shd) : rem_p[k];
			quo_n = take ? (quo_p[k] | (QW'(1) << B)) : quo_p[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else if (en) begin
				v_p[k+1] <= v_p[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k+1] <= rem_n;
				den_p[k+1] <= den_p[k];
				quo_p[k+1] <= quo_n;
				tag_p[k+1] <= tag_p[k];
			end
		end
	end

	assign out_valid = v_p[QW];
	assign quo       = quo_p[QW];
	assign out_tag   = tag_p[QW];

endmodule

FILE: rtl/rdr_checker.sv
// Port-level checks for radial_deadzone_rescale_unit, with its bind.
// Depends on rdr_pkg and the top level's ports.
module rdr_checker
	import rdr_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] corrected_x,
	input logic [SAMPLE_BITS-1:0] corrected_y,
	input logic [SAMPLE_BITS-2:0] magnitude
);

	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(corrected_x)
			&& $stable(corrected_y) && $stable(magnitude))
		else $error("result changed while stalled");

	// Offered input holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input dropped before transfer");

	// Backpressure only when a result is waiting
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	// Zero magnitude gives the center
	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && magnitude == '0 |-> corrected_x == '0 && corrected_y == '0)
		else $error("nonzero position at zero magnitude");

	// Rescaled axes stay within the symmetric range
	a_no_most_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> corrected_x != MOST_NEG && corrected_y != MOST_NEG)
		else $error("corrected axis reached most negative code");

endmodule

bind radial_deadzone_rescale_unit rdr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rdr_checker (.*);
